[sv/jsu_pkg.sv]
`timescale 1ns / 1ps

package jsu_pkg;

  // results one input byte can cause at most
  localparam int JSU_MAX_RES = 4;
  localparam int JSU_IDX_W   = 2;
  localparam int JSU_CNT_W   = 3;
  // default depth of the queue between front and back, in groups
  localparam int JSU_QDEPTH  = 4;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_END  = 2'd0;
  localparam logic [1:0] ERR_CTRL = 2'd1;
  localparam logic [1:0] ERR_HEX  = 2'd2;
  localparam logic [1:0] ERR_ESC  = 2'd3;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] err;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [JSU_CNT_W-1:0]       cnt;
    res_t [JSU_MAX_RES-1:0]     res;
  } grp_t;

endpackage

[sv/jsu_front.sv]
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       input_ended,
  output grp_t       grp,
  output logic       grp_push
);

  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_BSL,
    PH_HEX1,
    PH_HEX2,
    PH_HEX3,
    PH_HEX4
  } phase_t;

  typedef struct packed {
    logic [JSU_CNT_W-1:0]           cnt;
    logic [JSU_MAX_RES-1:0][7:0]    b;
  } enc_t;

  phase_t      phase_r, phase_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [15:0] held_r, held_nxt;
  logic        held_vld_r, held_vld_nxt;

  // utf-8 form of a code point
  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.cnt  = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.cnt  = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.cnt  = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.cnt  = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  // hex digit value, bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // escape letter to byte, bit 8 set when the letter is known
  function automatic logic [8:0] esc_dec(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h62:                 r = {1'b1, 8'h08};
      8'h66:                 r = {1'b1, 8'h0C};
      8'h6E:                 r = {1'b1, 8'h0A};
      8'h72:                 r = {1'b1, 8'h0D};
      8'h74:                 r = {1'b1, 8'h09};
      8'h22, 8'h5C, 8'h2F:   r = {1'b1, c};
      default:               r = '0;
    endcase
    return r;
  endfunction

  logic [4:0]  hx;
  logic [8:0]  esc;
  logic [15:0] cp;
  logic [20:0] joined;
  enc_t        held_enc, join_enc;
  logic [JSU_CNT_W-1:0] flush_n;
  res_t        extra;
  logic        use_extra, use_join, use_flush;

  assign hx       = hex_dec(data_byte);
  assign esc      = esc_dec(data_byte);
  assign cp       = {acc_r, hx[3:0]};
  assign joined   = {1'b0, held_r[9:0], cp[9:0]} + 21'h10000;
  assign held_enc = utf8_enc({5'd0, held_r});
  assign join_enc = utf8_enc(joined);
  assign flush_n  = held_vld_r ? held_enc.cnt : '0;

  // decode one byte into next state and a result group
  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    extra        = '0;
    use_extra    = 1'b0;
    use_join     = 1'b0;
    use_flush    = 1'b0;
    unique case (phase_r)
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        if (input_ended || !hx[4]) begin
          extra     = '{data: 8'd0, kind: KIND_ERR, err: ERR_HEX};
          use_extra = 1'b1;
        end else if (phase_r != PH_HEX4) begin
          acc_nxt   = {acc_r[7:0], hx[3:0]};
          phase_nxt = phase_t'(phase_r + 3'd1);
        end else begin
          phase_nxt = PH_PLAIN;
          acc_nxt   = '0;
          if (held_vld_r && held_r[15:10] == 6'b110110 && cp[15:10] == 6'b110111) begin
            use_join     = 1'b1;
            held_nxt     = '0;
            held_vld_nxt = 1'b0;
          end else begin
            use_flush    = 1'b1;
            held_nxt     = cp;
            held_vld_nxt = 1'b1;
          end
        end
      end
      PH_BSL: begin
        if (input_ended) begin
          extra     = '{data: 8'd0, kind: KIND_ERR, err: ERR_END};
          use_extra = 1'b1;
        end else if (data_byte == 8'h75) begin
          acc_nxt   = '0;
          phase_nxt = PH_HEX1;
        end else if (esc[8]) begin
          extra        = '{data: esc[7:0], kind: KIND_DATA, err: ERR_END};
          use_extra    = 1'b1;
          use_flush    = 1'b1;
          phase_nxt    = PH_PLAIN;
          held_nxt     = '0;
          held_vld_nxt = 1'b0;
        end else begin
          extra     = '{data: 8'd0, kind: KIND_ERR, err: ERR_ESC};
          use_extra = 1'b1;
        end
      end
      default: begin
        if (input_ended) begin
          extra     = '{data: 8'd0, kind: KIND_ERR, err: ERR_END};
          use_extra = 1'b1;
        end else if (data_byte == 8'h22) begin
          extra     = '{data: 8'd0, kind: KIND_DONE, err: ERR_END};
          use_extra = 1'b1;
          use_flush = 1'b1;
        end else if (data_byte <= 8'h1F) begin
          extra     = '{data: 8'd0, kind: KIND_ERR, err: ERR_CTRL};
          use_extra = 1'b1;
        end else if (data_byte == 8'h5C) begin
          phase_nxt = PH_BSL;
        end else begin
          extra        = '{data: data_byte, kind: KIND_DATA, err: ERR_END};
          use_extra    = 1'b1;
          use_flush    = 1'b1;
          phase_nxt    = PH_PLAIN;
          held_nxt     = '0;
          held_vld_nxt = 1'b0;
        end
      end
    endcase
    // string done or error: back to the start of a new string
    if (use_extra && extra.kind != KIND_DATA) begin
      phase_nxt    = PH_PLAIN;
      acc_nxt      = '0;
      held_nxt     = '0;
      held_vld_nxt = 1'b0;
    end
  end

  // pack the joined pair's bytes, or flushed bytes and the trailing result, into one group
  always_comb begin
    grp = '0;
    if (use_join) begin
      grp.cnt = join_enc.cnt;
      for (int i = 0; i < JSU_MAX_RES; i++) begin
        grp.res[i] = '{data: join_enc.b[i], kind: KIND_DATA, err: ERR_END};
      end
    end else begin
      for (int i = 0; i < JSU_MAX_RES; i++) begin
        if (use_flush && JSU_CNT_W'(i) < flush_n) begin
          grp.res[i] = '{data: held_enc.b[i], kind: KIND_DATA, err: ERR_END};
        end else if (use_extra && JSU_CNT_W'(i) == (use_flush ? flush_n : '0)) begin
          grp.res[i] = extra;
        end
      end
      grp.cnt = (use_flush ? flush_n : '0) + JSU_CNT_W'(use_extra);
    end
  end

  assign grp_push = take && (grp.cnt != '0);

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_PLAIN;
      acc_r      <= '0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

endmodule

[sv/jsu_fifo.sv]
`timescale 1ns / 1ps

module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = JSU_QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  grp_t wr_data,
  output logic full,
  input  logic rd_en,
  output grp_t rd_data,
  output logic rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  // group storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[sv/jsu_back.sv]
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  grp_t       q_data,
  input  logic       q_valid,
  output logic       q_pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [1:0] out_error_code,
  output logic       out_last,
  output logic       out_empty,
  input  logic       out_pop
);

  grp_t                 grp_r;
  logic                 vld_r;
  logic [JSU_IDX_W-1:0] idx_r;
  logic                 at_last;
  logic                 take;
  res_t                 cur;

  assign at_last = (JSU_CNT_W'(idx_r) + 1'b1) == grp_r.cnt;
  assign take    = out_pop && vld_r;
  assign q_pop   = q_valid && (!vld_r || (take && at_last));
  assign cur     = grp_r.res[idx_r];

  assign out_empty      = !vld_r;
  assign out_byte       = cur.data;
  assign out_kind       = cur.kind;
  assign out_error_code = cur.err;
  assign out_last       = at_last;

  // current group payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp_r <= q_data;
    end
  end

  // walk through the words of the current group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (take) begin
      if (at_last) begin
        vld_r <= 1'b0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule

[sv/json_string_unescape_utf8.sv]
`timescale 1ns / 1ps
// JSON string body decoder with UTF-8 output.
// Input channel: one raw byte of the string body per word (in_data_byte), or
// an end-of-input marker (in_input_ended). A word is taken on a clock edge
// with in_push high and in_full low; in_full is high only while the group
// queue between decoder and output stage holds QDEPTH groups.
// Result channel: one word per decoded UTF-8 byte, string-complete or error
// marker; out_last flags the final word caused by one input word. A word is
// shown while out_empty is low and leaves on an edge with out_pop high.
// Throughput: one input word per cycle while in_full is low, one result word
// per cycle while out_empty is low and out_pop high; an input word makes
// zero to four result words, so the single-word output stage draining each
// group sets the sustained input rate. The decoder writes a group into the
// queue on the accepting edge, and an idle output stage registers it next.
// Reset (synchronous, rst_n low) empties the queue and output stage and puts
// the decoder at the start of a string. A stalled receiver backs up the
// queue, after which in_full holds the sender off; no word is lost.
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int QDEPTH = JSU_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_input_ended,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  grp_t fr_grp, q_data;
  logic fr_push, q_full, q_valid, q_pop, take;

  assign take    = in_push && !q_full;
  assign in_full = q_full;

  // decoder
  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_data_byte),
    .input_ended (in_input_ended),
    .grp         (fr_grp),
    .grp_push    (fr_push)
  );

  // group queue
  jsu_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fr_push),
    .wr_data  (fr_grp),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .rd_valid (q_valid)
  );

  // output stage
  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_data),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop)
  );

endmodule
